@@ design/skt_pkg.sv @@
// Shared package for the sorted key table.
// Holds field widths, operation and status codes, and the cell control types.
// Used by the interfaces, skt_cell and sorted_key_table.
package skt_pkg;

  localparam int KEY_W    = 30;
  localparam int DATA_W   = 32;
  localparam int OP_W     = 2;
  localparam int STATUS_W = 3;

  // Largest key accepted by insert and remove
  localparam logic [KEY_W-1:0] KEY_MAX = KEY_W'(999999999);

  // Operation codes
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_DUMP   = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_ADDED     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DUP       = 3'd1;
  localparam logic [STATUS_W-1:0] ST_REMOVED   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOW_EMPTY = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd5;
  localparam logic [STATUS_W-1:0] ST_ENTRY     = 3'd6;
  localparam logic [STATUS_W-1:0] ST_BAD       = 3'd7;

  // Per-cycle command to every cell of the chain
  typedef struct packed {
    logic cmp;   // compare stored key against the incoming key
    logic ins;   // open a slot and insert the pending item
    logic rem;   // close the gap over the matching entry
    logic rot;   // rotate occupied entries one place toward cell 0
  } skt_cell_ctl_t;

  // Registered compare results of one cell
  typedef struct packed {
    logic lt;    // occupied and stored key below the compared key
    logic eq;    // occupied and stored key equal to the compared key
  } skt_cell_flags_t;

endpackage

@@ design/skt_if.sv @@
// Valid/ready channel interfaces for the sorted key table.
// Depends on skt_pkg for field widths.
interface skt_in_if;
  logic                        valid;
  logic                        ready;
  logic [skt_pkg::OP_W-1:0]    opcode;
  logic [skt_pkg::KEY_W-1:0]   key;
  logic [skt_pkg::DATA_W-1:0]  value;

  modport source (output valid, output opcode, output key, output value, input ready);
  modport sink   (input valid, input opcode, input key, input value, output ready);
endinterface

interface skt_out_if;
  logic                          valid;
  logic                          ready;
  logic [skt_pkg::STATUS_W-1:0]  status;
  logic [skt_pkg::KEY_W-1:0]     out_key;
  logic [skt_pkg::DATA_W-1:0]    out_value;
  logic                          last;

  modport source (output valid, output status, output out_key, output out_value,
                  output last, input ready);
  modport sink   (input valid, input status, input out_key, input out_value,
                  input last, output ready);
endinterface

@@ design/skt_cell.sv @@
// One cell of the sorted chain: holds a key and value and moves them to or
// from its neighbors on insert, remove and rotate. Depends on skt_pkg.
module skt_cell #(
  parameter int VALUE_BITS = 32,
  parameter int IDX        = 0,
  parameter int CNT_W      = 7
) (
  input  logic                         clk,
  input  skt_pkg::skt_cell_ctl_t       ctl,
  input  logic [CNT_W-1:0]             count,
  input  logic [skt_pkg::KEY_W-1:0]    cmp_key,
  input  logic [skt_pkg::KEY_W-1:0]    new_key,
  input  logic [VALUE_BITS-1:0]        new_val,
  input  logic                         left_lt,
  input  logic [skt_pkg::KEY_W-1:0]    left_key,
  input  logic [VALUE_BITS-1:0]        left_val,
  input  logic [skt_pkg::KEY_W-1:0]    right_key,
  input  logic [VALUE_BITS-1:0]        right_val,
  input  logic [skt_pkg::KEY_W-1:0]    wrap_key,
  input  logic [VALUE_BITS-1:0]        wrap_val,
  output logic [skt_pkg::KEY_W-1:0]    key,
  output logic [VALUE_BITS-1:0]        val,
  output skt_pkg::skt_cell_flags_t     flags
);

  localparam logic [CNT_W-1:0] IDX_C  = CNT_W'(IDX);
  localparam logic [CNT_W-1:0] IDX_P1 = CNT_W'(IDX + 1);

  logic [skt_pkg::KEY_W-1:0] key_r, key_nxt;
  logic [VALUE_BITS-1:0]     val_r, val_nxt;
  skt_pkg::skt_cell_flags_t  flags_r;
  logic                      occ;
  logic                      tail;

  // Occupancy follows from the fill count; the tail is the last occupied cell
  assign occ  = IDX_C < count;
  assign tail = count == IDX_P1;

  // Latch compare results for the incoming item
  always_ff @(posedge clk) begin
    if (ctl.cmp) begin
      flags_r.lt <= occ && (key_r < cmp_key);
      flags_r.eq <= occ && (key_r == cmp_key);
    end
  end

  // Select the next contents from self, neighbor or pending item
  always_comb begin
    key_nxt = key_r;
    val_nxt = val_r;
    if (ctl.ins) begin
      if (!flags_r.lt) begin
        if (left_lt) begin
          key_nxt = new_key;
          val_nxt = new_val;
        end else begin
          key_nxt = left_key;
          val_nxt = left_val;
        end
      end
    end else if (ctl.rem) begin
      if (occ && !flags_r.lt) begin
        key_nxt = right_key;
        val_nxt = right_val;
      end
    end else if (ctl.rot) begin
      if (tail) begin
        key_nxt = wrap_key;
        val_nxt = wrap_val;
      end else begin
        key_nxt = right_key;
        val_nxt = right_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    val_r <= val_nxt;
  end

  assign key   = key_r;
  assign val   = val_r;
  assign flags = flags_r;

endmodule

@@ design/sorted_key_table.sv @@
// Sorted key table: a chain of CAPACITY cells kept in ascending key order.
// Insert and remove: an item is taken only in the idle state; its single result is
// loaded into the output register in the execute state once the output slot is free,
// and only then is a new item taken. Dump of n entries: one rotation per emitted entry.
// Synchronous active-low reset clears the fill count, state, dump index and output
// valid; cell contents are left as they are. Depends on skt_pkg, skt_if, skt_cell.
module sorted_key_table #(
  parameter int CAPACITY   = 64,
  parameter int VALUE_BITS = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  skt_in_if.sink     in_ch,
  skt_out_if.source  out_ch
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);
  localparam logic [CNT_W-1:0] CNT_ZERO = '0;
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_DUMP = 3'b100
  } state_t;

  state_t                          state_r, state_nxt;
  logic [CNT_W-1:0]                count_r, count_nxt;
  logic [IDX_W-1:0]                dump_idx_r, dump_idx_nxt;
  logic [skt_pkg::OP_W-1:0]        req_op_r;
  logic [skt_pkg::KEY_W-1:0]       req_key_r;
  logic [VALUE_BITS-1:0]           req_val_r;
  logic                            key_ok_r;

  logic                            out_valid_r, out_valid_nxt;
  logic [skt_pkg::STATUS_W-1:0]    out_status_r, out_status_nxt;
  logic [skt_pkg::KEY_W-1:0]       out_key_r, out_key_nxt;
  logic [skt_pkg::DATA_W-1:0]      out_value_r, out_value_nxt;
  logic                            out_last_r, out_last_nxt;
  logic                            out_load;
  logic                            out_free;
  logic                            accept;
  logic                            found;
  logic                            dump_last;

  skt_pkg::skt_cell_ctl_t          ctl;
  logic [skt_pkg::KEY_W-1:0]       key_a [CAPACITY];
  logic [VALUE_BITS-1:0]           val_a [CAPACITY];
  skt_pkg::skt_cell_flags_t        flags_a [CAPACITY];
  logic [CAPACITY-1:0]             eq_vec;

  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;
  assign found       = |eq_vec;
  assign dump_last   = (CNT_W'(dump_idx_r) + CNT_ONE) == count_r;

  // Build the cell chain; the ends see themselves as missing neighbors
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                      left_lt;
    logic [skt_pkg::KEY_W-1:0] left_key, right_key;
    logic [VALUE_BITS-1:0]     left_val, right_val;

    if (i == 0) begin : g_first
      assign left_lt  = 1'b1;
      assign left_key = key_a[i];
      assign left_val = val_a[i];
    end else begin : g_mid
      assign left_lt  = flags_a[i-1].lt;
      assign left_key = key_a[i-1];
      assign left_val = val_a[i-1];
    end

    if (i == CAPACITY - 1) begin : g_end
      assign right_key = key_a[i];
      assign right_val = val_a[i];
    end else begin : g_inner
      assign right_key = key_a[i+1];
      assign right_val = val_a[i+1];
    end

    skt_cell #(
      .VALUE_BITS (VALUE_BITS),
      .IDX        (i),
      .CNT_W      (CNT_W)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .count     (count_r),
      .cmp_key   (in_ch.key),
      .new_key   (req_key_r),
      .new_val   (req_val_r),
      .left_lt   (left_lt),
      .left_key  (left_key),
      .left_val  (left_val),
      .right_key (right_key),
      .right_val (right_val),
      .wrap_key  (key_a[0]),
      .wrap_val  (val_a[0]),
      .key       (key_a[i]),
      .val       (val_a[i]),
      .flags     (flags_a[i])
    );

    assign eq_vec[i] = flags_a[i].eq;
  end

  // Hold the accepted item for the execute cycle
  always_ff @(posedge clk) begin
    if (accept) begin
      req_op_r  <= in_ch.opcode;
      req_key_r <= in_ch.key;
      req_val_r <= in_ch.value[VALUE_BITS-1:0];
      key_ok_r  <= (in_ch.key != '0) && (in_ch.key <= skt_pkg::KEY_MAX);
    end
  end

  // Sequence compare, execute and dump
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    dump_idx_nxt   = dump_idx_r;
    ctl            = '0;
    out_load       = 1'b0;
    out_status_nxt = skt_pkg::ST_BAD;
    out_key_nxt    = req_key_r;
    out_value_nxt  = '0;
    out_last_nxt   = 1'b1;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          ctl.cmp   = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
          case (req_op_r)
            skt_pkg::OP_INSERT: begin
              if (!key_ok_r) begin
                out_status_nxt = skt_pkg::ST_BAD;
              end else if (found) begin
                out_status_nxt = skt_pkg::ST_DUP;
              end else if (count_r == CNT_FULL) begin
                out_status_nxt = skt_pkg::ST_FULL;
              end else begin
                ctl.ins        = 1'b1;
                count_nxt      = count_r + CNT_ONE;
                out_status_nxt = skt_pkg::ST_ADDED;
              end
            end
            skt_pkg::OP_REMOVE: begin
              if (!key_ok_r || count_r == CNT_ZERO) begin
                out_status_nxt = skt_pkg::ST_BAD;
              end else if (!found) begin
                out_status_nxt = skt_pkg::ST_NOT_FOUND;
              end else begin
                ctl.rem        = 1'b1;
                count_nxt      = count_r - CNT_ONE;
                out_status_nxt = (count_r == CNT_ONE) ? skt_pkg::ST_NOW_EMPTY
                                                      : skt_pkg::ST_REMOVED;
              end
            end
            skt_pkg::OP_DUMP: begin
              if (count_r == CNT_ZERO) begin
                out_status_nxt = skt_pkg::ST_BAD;
              end else begin
                out_load     = 1'b0;
                dump_idx_nxt = '0;
                state_nxt    = S_DUMP;
              end
            end
            default: begin
              out_status_nxt = skt_pkg::ST_BAD;
            end
          endcase
        end
      end
      S_DUMP: begin
        // Emit cell 0 and rotate the occupied entries behind it
        if (out_free) begin
          out_load       = 1'b1;
          ctl.rot        = 1'b1;
          out_status_nxt = skt_pkg::ST_ENTRY;
          out_key_nxt    = key_a[0];
          out_value_nxt  = skt_pkg::DATA_W'(val_a[0]);
          out_last_nxt   = dump_last;
          if (dump_last) begin
            dump_idx_nxt = '0;
            state_nxt    = S_IDLE;
          end else begin
            dump_idx_nxt = dump_idx_r + IDX_W'(1);
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Drop the result once taken, load a new one when the slot is free
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      dump_idx_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      dump_idx_r  <= dump_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status_r <= out_status_nxt;
      out_key_r    <= out_key_nxt;
      out_value_r  <= out_value_nxt;
      out_last_r   <= out_last_nxt;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.status    = out_status_r;
  assign out_ch.out_key   = out_key_r;
  assign out_ch.out_value = out_value_r;
  assign out_ch.last      = out_last_r;

endmodule
